// ----- rtl/tcb_pkg.sv -----
// tcb_pkg: shared types and constants for the tcb spline keyframe evaluator
// used by tcb_mul, tcb_div and the top level; no dependencies
`timescale 1ns / 1ps

package tcb_pkg;

	localparam int NUM_KEYS = 8;
	localparam int KIDX_W   = $clog2(NUM_KEYS);
	localparam int ONE_Q14  = 16384;

	// shared multiplier: signed a by signed b, b taken in two 18-bit digits
	localparam int MA_W  = 44;
	localparam int MB_W  = 37;
	localparam int DIG_W = 18;
	localparam int MP_W  = MA_W + 2 * DIG_W;

	// divider: signed numerator by signed span
	localparam int NUM_W = 34;
	localparam int DEN_W = 17;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [15:0] tension;
		logic signed [15:0] continuity;
		logic signed [15:0] bias;
		logic        [15:0] frame;
	} key_row_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic            done;
		logic            neg;
		logic [MP_W-1:0] mag;
	} mul_rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic signed [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_FISS,
		S_FCAP,
		S_SETUP,
		S_MISS,
		S_MWAIT,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		ST_W0A, ST_W0B, ST_W1A, ST_W1B,
		ST_W2A, ST_W2B, ST_W3A, ST_W3B,
		ST_T0, ST_T1, ST_T2, ST_T3,
		ST_H0, ST_H1, ST_H2
	} step_t;

endpackage

// ----- rtl/tcb_mul.sv -----
// tcb_mul: shared sign-magnitude multiplier, 44 bits by two 18-bit digits
// depends on tcb_pkg; result magnitude valid once done is raised
`timescale 1ns / 1ps

module tcb_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  tcb_pkg::mul_req_t req,
	output tcb_pkg::mul_rsp_t rsp
);
	import tcb_pkg::*;

	logic [MA_W-1:0]       a_q;
	logic [2*DIG_W-1:0]    b_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  phase_q;
	logic                  done_q;
	logic [MP_W-1:0]       acc_q;
	logic [MA_W-1:0]       a_mag;
	logic [MB_W-1:0]       b_mag;
	logic [DIG_W-1:0]      digit;
	logic [MA_W+DIG_W-1:0] pp;

	assign a_mag = req.a[MA_W-1] ? MA_W'(-req.a) : MA_W'(req.a);
	assign b_mag = req.b[MB_W-1] ? MB_W'(-req.b) : MB_W'(req.b);
	assign digit = phase_q ? b_q[DIG_W-1:0] : b_q[2*DIG_W-1:DIG_W];
	assign pp    = (MA_W+DIG_W)'(a_q) * (MA_W+DIG_W)'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			phase_q <= 1'b1;
			if (phase_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a_mag;
			b_q   <= b_mag[2*DIG_W-1:0];
			neg_q <= req.a[MA_W-1] ^ req.b[MB_W-1];
		end else if (busy_q) begin
			// high digit first, then shift and add the low digit
			if (phase_q)
				acc_q <= {acc_q[MP_W-DIG_W-1:0], {DIG_W{1'b0}}} + MP_W'(pp);
			else
				acc_q <= MP_W'(pp);
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.mag  = acc_q;

endmodule

// ----- rtl/tcb_div.sv -----
// tcb_div: restoring divider, one quotient bit a cycle, truncating toward zero
// depends on tcb_pkg
`timescale 1ns / 1ps

module tcb_div (
	input  logic             clk,
	input  logic             arst_n,
	input  tcb_pkg::div_req_t req,
	output tcb_pkg::div_rsp_t rsp
);
	import tcb_pkg::*;

	localparam int NM_W  = NUM_W - 1;
	localparam int CNT_W = $clog2(NM_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  d_q;
	logic [NM_W-1:0]   q_q;
	logic              neg_q;
	logic [NUM_W-1:0]  n_mag;
	logic [DEN_W-1:0]  d_mag;
	logic [DEN_W+1:0]  trial;

	assign n_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign d_mag = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
	assign trial = {1'b0, rem_q, q_q[NM_W-1]} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			d_q   <= d_mag;
			q_q   <= n_mag[NM_W-1:0];
			neg_q <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
		end else if (busy_q) begin
			if (trial[DEN_W+1]) begin
				rem_q <= {rem_q[DEN_W-2:0], q_q[NM_W-1]};
				q_q   <= {q_q[NM_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				q_q   <= {q_q[NM_W-2:0], 1'b1};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

// ----- rtl/tcb_spline_keyframe_evaluator.sv -----
// tcb_spline_keyframe_evaluator: 3-d kochanek-bartels keyframe table and evaluator
// depends on tcb_pkg, tcb_mul, tcb_div
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, kind .. eval_frame    | item in
//   out     | out_valid, out_stall, point_x .. span_was_zero | item out
//
// a load item is written in idle and never raises in_stall; an evaluate item holds in_stall
// while it searches keys (one to five keys) and forms its products on the shared multiplier
// (29 products), with the span division running beside the weight products.
// a zero-length segment skips the products.
// the key table is undefined after reset until loaded; no clearing pass.
// in_stall is high while an evaluate is in work; one finished item can wait in the
// output register while the next item is accepted, and a full output register held
// by out_stall keeps the evaluator waiting in its output state.
`timescale 1ns / 1ps

module tcb_spline_keyframe_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [2:0]         key_index,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	input  logic signed [15:0] key_tension,
	input  logic signed [15:0] key_continuity,
	input  logic signed [15:0] key_bias,
	input  logic [15:0]        key_frame,
	input  logic signed [23:0] eval_frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [2:0]         segment_end,
	output logic               span_was_zero
);
	import tcb_pkg::*;

	localparam int SUM_W = 56;
	localparam int DT_W  = 41;
	localparam int AC_W  = 45;
	localparam int W_W   = 19;
	localparam int F_W   = 17;
	localparam int Q14_SH = 14;
	localparam logic [KIDX_W-1:0]     FIRST_E = KIDX_W'(2);
	localparam logic [KIDX_W-1:0]     LAST_E  = KIDX_W'(NUM_KEYS - 2);
	localparam logic signed [AC_W-1:0] ACC_POS = {3'b001, 42'd0};
	localparam logic signed [AC_W-1:0] ACC_NEG = {3'b111, 42'd0};
	localparam logic [42:0]           M_LIM   = {1'b1, 42'd0};
	localparam logic signed [AC_W-1:0] I32_MAX = {14'd0, 31'h7fffffff};
	localparam logic signed [AC_W-1:0] I32_MIN = {14'h3fff, 31'd0};

	function automatic logic signed [AC_W-1:0] sat_acc(input logic signed [AC_W-1:0] v);
		logic signed [AC_W-1:0] r;
		r = v;
		if (v > ACC_POS)
			r = ACC_POS;
		else if (v < ACC_NEG)
			r = ACC_NEG;
		return r;
	endfunction

	// key table
	key_row_t          key_mem [NUM_KEYS];
	key_row_t          rd_q;
	logic [KIDX_W-1:0] rd_addr;
	logic [KIDX_W+2:0] kidx_ext;
	logic              wr_en;
	key_row_t          wr_row;

	state_t state_q, state_d;
	step_t  step_q;
	logic   mul_start, div_start;

	logic [KIDX_W-1:0]  idx_q, e_q;
	logic [1:0]         fcnt_q, axis_q;
	logic [23:0]        frm_q;
	logic [95:0]        pos_q [4];
	logic signed [15:0] ten_s_q, con_s_q, bia_s_q, ten_e_q, con_e_q, bia_e_q;
	logic [15:0]        time_s_q, time_e_q;
	logic signed [33:0] tmp_q;
	logic signed [W_W-1:0] w_q [4];
	logic signed [SUM_W-1:0] sum_q;
	logic signed [DT_W-1:0]  dout_q, din_q;
	logic signed [AC_W-1:0]  acc_q;
	logic [95:0]        res_q;
	logic               zero_q;
	logic               out_valid_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [2:0]         seg_q;
	logic               zspan_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign kidx_ext = (KIDX_W+3)'(key_index);
	assign wr_en    = (state_q == S_IDLE) && in_valid && !kind &&
	                  (kidx_ext < (KIDX_W+3)'(NUM_KEYS));
	assign wr_row   = '{x: key_x, y: key_y, z: key_z, tension: key_tension,
	                    continuity: key_continuity, bias: key_bias, frame: key_frame};

	always_ff @(posedge clk) begin
		if (wr_en)
			key_mem[kidx_ext[KIDX_W-1:0]] <= wr_row;
		rd_q <= key_mem[rd_addr];
	end

	// operands for the current axis
	logic signed [31:0]     p0, p1, p2, p3;
	logic signed [32:0]     d1, d2, d3;
	logic signed [F_W-1:0]  ts, cps, cms, bps, bms, te, cpe, cme, bpe, bme;
	logic signed [DEN_W-1:0] span;
	logic signed [24:0]     fdiff;
	logic                   hit, is_h;

	assign p0 = pos_q[0][31:0];
	assign p1 = pos_q[1][31:0];
	assign p2 = pos_q[2][31:0];
	assign p3 = pos_q[3][31:0];
	assign d1 = $signed({p1[31], p1}) - $signed({p0[31], p0});
	assign d2 = $signed({p2[31], p2}) - $signed({p1[31], p1});
	assign d3 = $signed({p3[31], p3}) - $signed({p2[31], p2});

	assign ts  = $signed(F_W'(ONE_Q14)) - $signed({ten_s_q[15], ten_s_q});
	assign cps = $signed(F_W'(ONE_Q14)) + $signed({con_s_q[15], con_s_q});
	assign cms = $signed(F_W'(ONE_Q14)) - $signed({con_s_q[15], con_s_q});
	assign bps = $signed(F_W'(ONE_Q14)) + $signed({bia_s_q[15], bia_s_q});
	assign bms = $signed(F_W'(ONE_Q14)) - $signed({bia_s_q[15], bia_s_q});
	assign te  = $signed(F_W'(ONE_Q14)) - $signed({ten_e_q[15], ten_e_q});
	assign cpe = $signed(F_W'(ONE_Q14)) + $signed({con_e_q[15], con_e_q});
	assign cme = $signed(F_W'(ONE_Q14)) - $signed({con_e_q[15], con_e_q});
	assign bpe = $signed(F_W'(ONE_Q14)) + $signed({bia_e_q[15], bia_e_q});
	assign bme = $signed(F_W'(ONE_Q14)) - $signed({bia_e_q[15], bia_e_q});

	assign span  = $signed({1'b0, time_e_q}) - $signed({1'b0, time_s_q});
	assign fdiff = $signed({1'b0, frm_q}) - $signed({1'b0, time_s_q, 8'h00});
	assign hit   = ({rd_q.frame, 8'h00} >= frm_q) || (idx_q == LAST_E);
	assign is_h  = (step_q == ST_H0) || (step_q == ST_H1) || (step_q == ST_H2);

	// multiplier operand selection
	always_comb begin
		mul_req.start = mul_start;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (step_q)
			ST_W0A: begin mul_req.a = MA_W'(ts);    mul_req.b = MB_W'(cps); end
			ST_W0B: begin mul_req.a = MA_W'(tmp_q); mul_req.b = MB_W'(bps); end
			ST_W1A: begin mul_req.a = MA_W'(ts);    mul_req.b = MB_W'(cms); end
			ST_W1B: begin mul_req.a = MA_W'(tmp_q); mul_req.b = MB_W'(bms); end
			ST_W2A: begin mul_req.a = MA_W'(te);    mul_req.b = MB_W'(cme); end
			ST_W2B: begin mul_req.a = MA_W'(tmp_q); mul_req.b = MB_W'(bpe); end
			ST_W3A: begin mul_req.a = MA_W'(te);    mul_req.b = MB_W'(cpe); end
			ST_W3B: begin mul_req.a = MA_W'(tmp_q); mul_req.b = MB_W'(bme); end
			ST_T0:  begin mul_req.a = MA_W'(d1);    mul_req.b = MB_W'(w_q[0]); end
			ST_T1:  begin mul_req.a = MA_W'(d2);    mul_req.b = MB_W'(w_q[1]); end
			ST_T2:  begin mul_req.a = MA_W'(d2);    mul_req.b = MB_W'(w_q[2]); end
			ST_T3:  begin mul_req.a = MA_W'(d3);    mul_req.b = MB_W'(w_q[3]); end
			ST_H0, ST_H1, ST_H2: begin
				mul_req.a = $signed(acc_q[MA_W-1:0]);
				mul_req.b = MB_W'(div_rsp.quot);
			end
			default: begin mul_req.a = '0; mul_req.b = '0; end
		endcase
	end

	assign div_req.start = div_start;
	assign div_req.num   = $signed({fdiff[24], fdiff, 8'h00});
	assign div_req.den   = span;

	tcb_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	tcb_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// product post-processing
	logic signed [MP_W:0]    prod;
	logic signed [SUM_W-1:0] tsum, tbias, tquo;
	logic signed [DT_W-1:0]  tang;
	logic signed [W_W-1:0]   wval;
	logic [MP_W-17:0]        mhi;
	logic [42:0]             mclip;
	logic signed [AC_W-1:0]  mu, dx, doutx, dinx, tangx, h0, h1, h2, seed;
	logic signed [31:0]      h2c;

	assign prod  = mul_rsp.neg ? -$signed({1'b0, mul_rsp.mag}) : $signed({1'b0, mul_rsp.mag});
	assign tsum  = sum_q + $signed(prod[SUM_W-1:0]);
	// bias negative sums so the arithmetic shift rounds toward zero
	assign tbias = tsum[SUM_W-1] ? $signed(SUM_W'(ONE_Q14 - 1)) : '0;
	assign tquo  = (tsum + tbias) >>> Q14_SH;
	assign tang  = $signed(tquo[DT_W-1:0]);
	assign wval  = mul_rsp.neg ? -$signed({1'b0, mul_rsp.mag[46:29]}) :
	                             $signed({1'b0, mul_rsp.mag[46:29]});
	assign mhi   = mul_rsp.mag[MP_W-1:16];
	assign mclip = (mhi > (MP_W-16)'(M_LIM)) ? M_LIM : mhi[42:0];
	assign mu    = mul_rsp.neg ? -$signed({2'b00, mclip}) : $signed({2'b00, mclip});
	assign dx    = AC_W'(d2);
	assign doutx = AC_W'(dout_q);
	assign dinx  = AC_W'(din_q);
	assign tangx = AC_W'(tang);
	assign seed  = doutx + tangx - dx - dx;
	assign h0    = sat_acc(mu + dx + dx + dx - doutx - doutx - dinx);
	assign h1    = sat_acc(mu + doutx);
	assign h2    = mu + AC_W'(p1);
	assign h2c   = (h2 > I32_MAX) ? 32'sh7fffffff :
	               (h2 < I32_MIN) ? 32'sh80000000 : h2[31:0];

	// sequencer
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		rd_addr   = idx_q;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: if (in_valid && kind) state_d = S_SRCH;
			S_SRCH: state_d = S_CMP;
			S_CMP:  state_d = hit ? S_FISS : S_SRCH;
			S_FISS: begin
				rd_addr = e_q + KIDX_W'(fcnt_q) - FIRST_E;
				state_d = S_FCAP;
			end
			S_FCAP: state_d = (fcnt_q == 2'd3) ? S_SETUP : S_FISS;
			S_SETUP: begin
				if (span == '0) begin
					state_d = S_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = S_MISS;
				end
			end
			S_MISS: begin
				if (!(is_h && div_rsp.busy)) begin
					mul_start = 1'b1;
					state_d   = S_MWAIT;
				end
			end
			S_MWAIT: begin
				if (mul_rsp.done)
					state_d = (step_q == ST_H2 && axis_q == 2'd2) ? S_OUT : S_MISS;
			end
			S_OUT: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && state_d == S_IDLE)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				frm_q <= eval_frame[23] ? 24'd1 : eval_frame;
				idx_q <= FIRST_E;
			end
			S_CMP: begin
				if (hit) begin
					e_q    <= idx_q;
					fcnt_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_FCAP: begin
				pos_q[fcnt_q] <= {rd_q.z, rd_q.y, rd_q.x};
				if (fcnt_q == 2'd1) begin
					ten_s_q  <= rd_q.tension;
					con_s_q  <= rd_q.continuity;
					bia_s_q  <= rd_q.bias;
					time_s_q <= rd_q.frame;
				end
				if (fcnt_q == 2'd2) begin
					ten_e_q  <= rd_q.tension;
					con_e_q  <= rd_q.continuity;
					bia_e_q  <= rd_q.bias;
					time_e_q <= rd_q.frame;
				end
				fcnt_q <= fcnt_q + 1'b1;
			end
			S_SETUP: begin
				step_q <= ST_W0A;
				axis_q <= 2'd0;
				res_q  <= pos_q[1];
				zero_q <= (span == '0);
			end
			S_MWAIT: begin
				if (mul_rsp.done) begin
					case (step_q)
						ST_W0A, ST_W1A, ST_W2A, ST_W3A: tmp_q <= prod[33:0];
						ST_W0B: w_q[0] <= wval;
						ST_W1B: w_q[1] <= wval;
						ST_W2B: w_q[2] <= wval;
						ST_W3B: w_q[3] <= wval;
						ST_T0, ST_T2: sum_q <= $signed(prod[SUM_W-1:0]);
						ST_T1: dout_q <= tang;
						ST_T3: begin
							din_q <= tang;
							acc_q <= seed;
						end
						ST_H0: acc_q <= h0;
						ST_H1: acc_q <= h1;
						ST_H2: begin
							res_q  <= {h2c, res_q[95:32]};
							axis_q <= axis_q + 1'b1;
							for (int k = 0; k < 4; k++)
								pos_q[k] <= {pos_q[k][31:0], pos_q[k][95:32]};
						end
						default: tmp_q <= tmp_q;
					endcase
					case (step_q)
						ST_W0A: step_q <= ST_W0B;
						ST_W0B: step_q <= ST_W1A;
						ST_W1A: step_q <= ST_W1B;
						ST_W1B: step_q <= ST_W2A;
						ST_W2A: step_q <= ST_W2B;
						ST_W2B: step_q <= ST_W3A;
						ST_W3A: step_q <= ST_W3B;
						ST_W3B: step_q <= ST_T0;
						ST_T0:  step_q <= ST_T1;
						ST_T1:  step_q <= ST_T2;
						ST_T2:  step_q <= ST_T3;
						ST_T3:  step_q <= ST_H0;
						ST_H0:  step_q <= ST_H1;
						ST_H1:  step_q <= ST_H2;
						default: step_q <= ST_T0;
					endcase
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					px_q    <= res_q[31:0];
					py_q    <= res_q[63:32];
					pz_q    <= res_q[95:64];
					seg_q   <= e_q + 3'd0 == e_q ? 3'((KIDX_W+3)'(e_q)) : 3'd0;
					zspan_q <= zero_q;
				end
			end
			default: frm_q <= frm_q;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign point_x       = px_q;
	assign point_y       = py_q;
	assign point_z       = pz_q;
	assign segment_end   = seg_q;
	assign span_was_zero = zspan_q;

`ifndef SYNTHESIS
	a_out_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && state_d == S_IDLE) |=> out_valid)
		else $error("finished item not presented");
	a_u_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MISS && mul_start && is_h) |-> !div_rsp.busy)
		else $error("u used before division finished");
	a_end_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SETUP) |-> (e_q >= FIRST_E && e_q <= LAST_E))
		else $error("segment end key out of range");
	a_mul_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> !mul_rsp.done)
		else $error("multiplier done flag not cleared on start");
`endif

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for tcb_spline_keyframe_evaluator, loads keys and evaluates
// the spline, results checked against a bit-exact fixed-point predictor; depends on the rtl
`timescale 1ns / 1ps

module tb_top;

	localparam longint SAT_LIM   = longint'(1) << 42;
	localparam int     IDLE_LIM  = 4000;
	localparam int     RAND_ITEMS = 2000;
	localparam bit     KIND_LOAD = 1'b0;
	localparam bit     KIND_EVAL = 1'b1;

	typedef struct {
		bit                 kind;
		logic [2:0]         idx;
		logic signed [31:0] x, y, z;
		logic signed [15:0] t, c, b;
		logic [15:0]        fr;
		logic signed [23:0] ev;
		bit                 typed;
		logic signed [31:0] ex, ey, ez;
		logic [2:0]         eseg;
		logic               ezero;
	} item_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic [2:0]         seg;
		logic               zero;
	} point_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall;
	logic               kind;
	logic [2:0]         key_index;
	logic signed [31:0] key_x, key_y, key_z;
	logic signed [15:0] key_tension, key_continuity, key_bias;
	logic [15:0]        key_frame;
	logic signed [23:0] eval_frame;
	logic signed [31:0] point_x, point_y, point_z;
	logic [2:0]         segment_end;
	logic               span_was_zero;

	tcb_spline_keyframe_evaluator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key_index(key_index),
		.key_x(key_x), .key_y(key_y), .key_z(key_z),
		.key_tension(key_tension), .key_continuity(key_continuity), .key_bias(key_bias),
		.key_frame(key_frame), .eval_frame(eval_frame),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.segment_end(segment_end), .span_was_zero(span_was_zero)
	);

	// shadow key table
	longint kx[8], ky[8], kz[8], kt[8], kc[8], kb[8], kf[8];
	point_t pending_points[$];
	int     errors = 0;
	int     idle_cycles = 0;
	bit     calm = 0;

	initial clk = 0;
	always #10 clk = ~clk;

	function automatic longint kb_weight(longint a, longint b, longint c);
		return (a * b * c) / (longint'(1) << 29);
	endfunction

	function automatic longint clamp42(longint v);
		if (v > SAT_LIM) return SAT_LIM;
		if (v < -SAT_LIM) return -SAT_LIM;
		return v;
	endfunction

	// a * u / 2^16, toward zero, magnitude saturated
	function automatic longint scale_by_u(longint a, longint u);
		bit neg;
		longint unsigned ua, ub, m;
		neg = (a < 0) != (u < 0);
		ua = a < 0 ? -a : a;
		ub = u < 0 ? -u : u;
		m = ua * (ub >> 16) + ((ua * (ub & 64'hFFFF)) >> 16);
		if (m > SAT_LIM) m = SAT_LIM;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] hermite_axis(longint pm, longint ps, longint pe,
			longint pn, longint w0, longint w1, longint w2, longint w3, longint u);
		longint d, dout, din, acc;
		d = pe - ps;
		dout = (w0 * (ps - pm) + w1 * (pe - ps)) / 16384;
		din = (w2 * (pe - ps) + w3 * (pn - pe)) / 16384;
		acc = dout + din - 2 * d;
		acc = clamp42(scale_by_u(acc, u) + 3 * d - 2 * dout - din);
		acc = clamp42(scale_by_u(acc, u) + dout);
		acc = scale_by_u(acc, u) + ps;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		return acc[31:0];
	endfunction

	function automatic point_t predict_point(logic signed [23:0] ev);
		point_t r;
		longint frm, span, u, w0, w1, w2, w3, ts, cs, bs, te, ce, be;
		int e, s;
		frm = ev;
		if (frm < 0) frm = 1;
		e = 6;
		for (int i = 2; i <= 6; i++)
			if (kf[i] * 256 >= frm) begin
				e = i;
				break;
			end
		s = e - 1;
		span = kf[e] - kf[s];
		r.seg = e[2:0];
		r.zero = (span == 0);
		if (span == 0) begin
			r.x = kx[s][31:0];
			r.y = ky[s][31:0];
			r.z = kz[s][31:0];
		end else begin
			ts = 16384 - kt[s]; cs = kc[s]; bs = kb[s];
			te = 16384 - kt[e]; ce = kc[e]; be = kb[e];
			u = ((frm - kf[s] * 256) * 256) / span;
			w0 = kb_weight(ts, 16384 + cs, 16384 + bs);
			w1 = kb_weight(ts, 16384 - cs, 16384 - bs);
			w2 = kb_weight(te, 16384 - ce, 16384 + be);
			w3 = kb_weight(te, 16384 + ce, 16384 - be);
			r.x = hermite_axis(kx[s-1], kx[s], kx[e], kx[e+1], w0, w1, w2, w3, u);
			r.y = hermite_axis(ky[s-1], ky[s], ky[e], ky[e+1], w0, w1, w2, w3, u);
			r.z = hermite_axis(kz[s-1], kz[s], kz[e], kz[e+1], w0, w1, w2, w3, u);
		end
		return r;
	endfunction

	function automatic item_t load_item(int idx, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, int t, int c, int b, int fr);
		item_t it;
		it = '{default: 0};
		it.kind = KIND_LOAD;
		it.idx = 3'(idx);
		it.x = x; it.y = y; it.z = z;
		it.t = 16'(t); it.c = 16'(c); it.b = 16'(b);
		it.fr = 16'(fr);
		it.ev = 24'($urandom);
		return it;
	endfunction

	function automatic item_t eval_item(logic signed [23:0] ev);
		item_t it;
		it = '{default: 0};
		it.kind = KIND_EVAL;
		it.idx = 3'($urandom);
		it.ev = ev;
		return it;
	endfunction

	function automatic item_t eval_typed(logic signed [23:0] ev, logic signed [31:0] ex,
			logic signed [31:0] ey, logic signed [31:0] ez, int seg, bit zero);
		item_t it;
		it = eval_item(ev);
		it.typed = 1;
		it.ex = ex; it.ey = ey; it.ez = ez;
		it.eseg = 3'(seg);
		it.ezero = zero;
		return it;
	endfunction

	task automatic send(item_t it);
		int gap;
		point_t p;
		gap = calm ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		kind <= it.kind;
		key_index <= it.idx;
		key_x <= it.x; key_y <= it.y; key_z <= it.z;
		key_tension <= it.t; key_continuity <= it.c; key_bias <= it.b;
		key_frame <= it.fr;
		eval_frame <= it.ev;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		if (it.kind == KIND_LOAD) begin
			kx[it.idx] = it.x; ky[it.idx] = it.y; kz[it.idx] = it.z;
			kt[it.idx] = it.t; kc[it.idx] = it.c; kb[it.idx] = it.b;
			kf[it.idx] = it.fr;
		end else if (it.typed) begin
			p.x = it.ex; p.y = it.ey; p.z = it.ez;
			p.seg = it.eseg; p.zero = it.ezero;
			pending_points.push_back(p);
		end else begin
			pending_points.push_back(predict_point(it.ev));
		end
	endtask

	// drop valid before waiting so the last item is not taken twice
	task automatic drain_points();
		@(negedge clk);
		in_valid <= 0;
		while (pending_points.size() != 0) @(posedge clk);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic signed [31:0] rnd_pos(int mode);
		case (mode)
			0: return $urandom_range(0, 2097152) - 1048576;
			1: return $urandom;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	function automatic int rnd_q14();
		case ($urandom_range(0, 7))
			0: return -16384;
			1: return 16384;
			2: return 0;
			default: return $urandom_range(0, 32768) - 16384;
		endcase
	endfunction

	task automatic load_table();
		int mode, base, fr;
		bit sorted;
		mode = $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2);
		sorted = $urandom_range(0, 7) != 0;
		base = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 60000);
		fr = base;
		for (int i = 0; i < 8; i++) begin
			if (sorted) begin
				if ($urandom_range(0, 5) != 0) fr = fr + $urandom_range(1, 40);
				if (fr > 65535) fr = 65535;
			end else begin
				fr = $urandom_range(0, 1) ? $urandom_range(0, 65535) : base + $urandom_range(0, 30);
			end
			send(load_item(i, rnd_pos(mode), rnd_pos(mode), rnd_pos(mode),
				rnd_q14(), rnd_q14(), rnd_q14(), fr));
		end
	endtask

	// sink side
	initial begin
		int n;
		out_stall = 0;
		forever begin
			n = calm ? 0 : $urandom_range(0, 7);
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		point_t w;
		if (out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				w = pending_points.pop_front();
				if (point_x !== w.x) report("point_x", point_x, w.x);
				if (point_y !== w.y) report("point_y", point_y, w.y);
				if (point_z !== w.z) report("point_z", point_z, w.z);
				if (segment_end !== w.seg) report("segment_end", segment_end, w.seg);
				if (span_was_zero !== w.zero) report("span_was_zero", span_was_zero, w.zero);
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		item_t plan[$];
		int lo, hi;
		arst_n = 0;
		in_valid = 0;
		kind = 0; key_index = 0;
		key_x = 0; key_y = 0; key_z = 0;
		key_tension = 0; key_continuity = 0; key_bias = 0;
		key_frame = 0; eval_frame = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// every key is written before the first evaluate
		plan.push_back(load_item(0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(load_item(1, 32'sh7fffffff, 32'sh80000000, 100, 16384, -16384, 16384, 5));
		plan.push_back(load_item(2, -5, 12, 0, -16384, 16384, -16384, 5));
		plan.push_back(load_item(3, 256, -256, 65536, 8192, 0, -8192, 10));
		plan.push_back(load_item(4, 32'sh80000000, 32'sh7fffffff, -1, 0, 16384, 0, 20));
		plan.push_back(load_item(5, 1234, -1234, 42, 0, 0, 0, 30));
		plan.push_back(load_item(6, 9999, 7, -7, 0, 0, 0, 30));
		plan.push_back(load_item(7, 5000, 5000, 5000, -16384, -16384, -16384, 65535));
		// zero length segments return the start key
		plan.push_back(eval_typed(0, 32'sh7fffffff, 32'sh80000000, 100, 2, 1));
		plan.push_back(eval_typed(-24'sd1, 32'sh7fffffff, 32'sh80000000, 100, 2, 1));
		plan.push_back(eval_typed(24'sh800000, 32'sh7fffffff, 32'sh80000000, 100, 2, 1));
		plan.push_back(eval_typed(24'sh7fffff, 1234, -1234, 42, 6, 1));
		plan.push_back(eval_item(24'(8 * 256 + 128)));
		plan.push_back(eval_item(24'(10 * 256)));
		plan.push_back(eval_item(24'(15 * 256 + 1)));
		plan.push_back(eval_item(24'(25 * 256)));
		// long final span, then a decreasing one
		plan.push_back(load_item(6, -32'sd70000, 32'sh7fffffff, 3, 16384, 16384, 16384, 65535));
		plan.push_back(eval_item(24'sh7fffff));
		plan.push_back(eval_item(24'(40 * 256)));
		plan.push_back(load_item(3, 300, 300, 300, 16384, 0, 0, 0));
		plan.push_back(eval_item(24'(2 * 256)));
		plan.push_back(eval_item(24'(7 * 256 + 77)));
		plan.push_back(eval_item(-24'sd500));
		calm = 1;
		foreach (plan[i]) send(plan[i]);
		calm = 0;

		// hold off until every result is back
		drain_points();

		load_table();
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 200 == 100) calm = !calm;
			if ($urandom_range(0, 79) == 0) load_table();
			else if ($urandom_range(0, 5) == 0)
				send(load_item($urandom_range(0, 7), rnd_pos($urandom_range(0, 2)),
					rnd_pos($urandom_range(0, 2)), rnd_pos($urandom_range(0, 2)),
					rnd_q14(), rnd_q14(), rnd_q14(),
					$urandom_range(0, 1) ? $urandom_range(0, 65535) :
						int'(kf[$urandom_range(0, 7)])));
			else if ($urandom_range(0, 4) == 0)
				send(eval_item(24'($urandom)));
			else begin
				lo = int'(kf[1] * 256 - 512);
				hi = int'(kf[6] * 256 + 512);
				send(eval_item(24'($urandom_range(hi, lo))));
			end
		end
		calm = 0;
		@(negedge clk);
		in_valid <= 0;

		drain_points();
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_points.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
